[design/stack_machine_execute_unit_macros.svh]
// Assertion macros used by the port-level checker of the stack machine.
// Depends on nothing; include by bare file name.
`ifndef STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[design/sme_pkg.sv]
// Package of the stack machine execute unit: sizes, opcodes, error codes, beats, commands.
// Depends on nothing.
package sme_pkg;
    localparam int STACK_DEPTH    = 64;
    localparam int REGISTER_COUNT = 8;
    localparam int PROGRAM_WORDS  = 1024;
    localparam int SP_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int RI_W  = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam int PC_W  = 11;

    localparam logic [4:0] OP_HLT = 5'd0, OP_PUSH = 5'd1, OP_PUSHREG = 5'd2,
        OP_POP = 5'd3, OP_POPREG = 5'd4, OP_IN = 5'd5, OP_DMP = 5'd6, OP_OUT = 5'd7,
        OP_ADD = 5'd8, OP_SUB = 5'd9, OP_MUL = 5'd10, OP_DIV = 5'd11, OP_MOD = 5'd12,
        OP_SQR = 5'd13, OP_JMP = 5'd14, OP_JB = 5'd15, OP_JBE = 5'd16, OP_JA = 5'd17,
        OP_JAE = 5'd18, OP_JE = 5'd19, OP_JNE = 5'd20;

    localparam logic [3:0] ERR_NONE = 4'd0, ERR_UNDER = 4'd1, ERR_OVER = 4'd2,
        ERR_DIVZ = 4'd3, ERR_NSQRT = 4'd4, ERR_TARGET = 4'd5, ERR_REG = 4'd6,
        ERR_OPCODE = 4'd7, ERR_PC = 4'd8;

    typedef struct packed {
        logic [4:0]         mode;
        logic signed [31:0] operand;
        logic signed [31:0] in_value;
    } t_in_beat;

    typedef struct packed {
        logic [10:0]        next_pc;
        logic               out_valid;
        logic signed [31:0] out_value;
        logic               halted;
        logic [3:0]         error_code;
    } t_out_beat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch an instruction and fetch the stack top
        logic read2;     // fetch the second entry
        logic exec;      // decode, check and do non-iterative work
        logic iter;      // one step of the divide or square root unit
        logic finish;    // write the iterative result and form the beat
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_iter; // decoded instruction uses the iterative unit
        logic iter_last; // the current step is the last one
    } t_status;
endpackage

[design/sme_ctrl.sv]
// Controller of the stack machine execute unit: sequences fetch, execute,
// iterate and result delivery. Depends on sme_pkg.
module sme_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  sme_pkg::t_status  i_status,
    output sme_pkg::t_cmd     o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0, S_READ2 = 3'd1, S_EXEC = 3'd2,
        S_ITER = 3'd3, S_FIN = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       w_take;

    // The input is taken only while idle; the output register frees on delivery.
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign w_take  = i_valid && !o_stall;
    assign o_valid = r_ovalid;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_ovalid = r_ovalid && i_stall;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    o_cmd.load = 1'b1;
                    n_state = S_READ2;
                end
            end
            S_READ2: begin
                o_cmd.read2 = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!r_ovalid || !i_stall) begin
                    o_cmd.exec = 1'b1;
                    if (i_status.need_iter) begin
                        n_state = S_ITER;
                    end else begin
                        n_ovalid = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_ITER: begin
                o_cmd.iter = 1'b1;
                if (i_status.iter_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovalid || !i_stall) begin
                    o_cmd.finish = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
        end
    end
endmodule

[design/sme_dpath.sv]
// Datapath of the stack machine execute unit: stack memory, register file,
// pc, ALU, iterative divide and square root, output register. Depends on sme_pkg.
module sme_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [10:0]        i_cfg_wdata,
    input  sme_pkg::t_in_beat  i_beat,
    input  sme_pkg::t_cmd      i_cmd,
    output sme_pkg::t_status   o_status,
    output sme_pkg::t_out_beat o_beat
);
    localparam int CNT_W = sme_pkg::CNT_W;
    localparam int SP_W  = sme_pkg::SP_W;
    localparam int RI_W  = sme_pkg::RI_W;

    logic [31:0] r_stack [sme_pkg::STACK_DEPTH];
    logic [31:0] r_regs [sme_pkg::REGISTER_COUNT];
    logic [CNT_W-1:0] r_cnt;
    logic [10:0] r_len;
    logic [10:0] r_pc;
    logic        r_stop;
    logic [3:0]  r_err;
    logic [4:0]  r_mode;
    logic [31:0] r_opnd, r_inval;
    logic [31:0] r_top, r_sec, r_rd;
    sme_pkg::t_out_beat r_out;

    // Iterative unit: remainder/quotient or root, step counter.
    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic [5:0]  r_step;
    logic        r_neg_q, r_neg_r;

    logic [11:0] w_len;
    logic        w_two, w_jump, w_arith_iter, w_reg_bad, w_ltst, w_ltts;
    logic [3:0]  w_err;
    logic [10:0] w_npc;
    logic        w_take;
    logic [31:0] w_res, w_mag_a, w_mag_b;
    logic [32:0] w_trial;
    logic [34:0] w_strial;
    logic [31:0] w_root_next, w_fin;
    logic [SP_W-1:0] w_tidx, w_sidx;

    assign w_len = (r_len > 11'(sme_pkg::PROGRAM_WORDS)) ? 12'(sme_pkg::PROGRAM_WORDS)
                                                         : {1'b0, r_len};
    assign w_two = (r_mode == sme_pkg::OP_PUSH) || (r_mode == sme_pkg::OP_PUSHREG) ||
                   (r_mode == sme_pkg::OP_POPREG) ||
                   (r_mode >= sme_pkg::OP_JMP && r_mode <= sme_pkg::OP_JNE);
    assign w_jump = (r_mode >= sme_pkg::OP_JMP) && (r_mode <= sme_pkg::OP_JNE);
    assign w_reg_bad = (r_opnd >= 32'(sme_pkg::REGISTER_COUNT));
    assign w_ltst = $signed(r_sec) < $signed(r_top);
    assign w_ltts = $signed(r_top) < $signed(r_sec);
    assign w_tidx = SP_W'(r_cnt - CNT_W'(1));
    assign w_sidx = SP_W'(r_cnt - CNT_W'(2));
    assign w_mag_a = r_sec[31] ? -r_sec : r_sec;
    assign w_mag_b = r_top[31] ? -r_top : r_top;

    // Decode and checks in the model's priority order.
    always_comb begin
        w_err = sme_pkg::ERR_NONE;
        w_npc = r_pc;
        w_res = 32'd0;
        w_take = 1'b0;
        w_arith_iter = 1'b0;
        if ({1'b0, r_pc} >= w_len || (w_two && ({1'b0, r_pc} + 12'd1 >= w_len))) begin
            w_err = sme_pkg::ERR_PC;
        end else if (r_mode > sme_pkg::OP_JNE) begin
            w_err = sme_pkg::ERR_OPCODE;
        end else if (w_jump && (r_opnd[31] || r_opnd >= {20'd0, w_len})) begin
            w_err = sme_pkg::ERR_TARGET;
        end else begin
            case (r_mode)
                sme_pkg::OP_HLT: w_npc = r_pc;
                sme_pkg::OP_PUSH, sme_pkg::OP_PUSHREG, sme_pkg::OP_IN: begin
                    if (r_mode == sme_pkg::OP_PUSHREG && w_reg_bad) begin
                        w_err = sme_pkg::ERR_REG;
                    end else if (r_cnt >= CNT_W'(sme_pkg::STACK_DEPTH)) begin
                        w_err = sme_pkg::ERR_OVER;
                    end else begin
                        w_npc = r_pc + ((r_mode == sme_pkg::OP_IN) ? 11'd1 : 11'd2);
                    end
                end
                sme_pkg::OP_POP, sme_pkg::OP_POPREG: begin
                    if (r_cnt == '0) begin
                        w_err = sme_pkg::ERR_UNDER;
                    end else if (r_mode == sme_pkg::OP_POPREG && w_reg_bad) begin
                        w_err = sme_pkg::ERR_REG;
                    end else begin
                        w_npc = r_pc + ((r_mode == sme_pkg::OP_POPREG) ? 11'd2 : 11'd1);
                    end
                end
                sme_pkg::OP_DMP: w_npc = r_pc + 11'd1;
                sme_pkg::OP_OUT: begin
                    if (r_cnt == '0) w_err = sme_pkg::ERR_UNDER;
                    else w_npc = r_pc + 11'd1;
                end
                sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
                sme_pkg::OP_MOD: begin
                    if (r_cnt < CNT_W'(2)) begin
                        w_err = sme_pkg::ERR_UNDER;
                    end else if ((r_mode == sme_pkg::OP_DIV || r_mode == sme_pkg::OP_MOD)
                                 && r_top == 32'd0) begin
                        w_err = sme_pkg::ERR_DIVZ;
                    end else begin
                        w_npc = r_pc + 11'd1;
                        w_arith_iter = (r_mode == sme_pkg::OP_DIV) ||
                                       (r_mode == sme_pkg::OP_MOD);
                        if (r_mode == sme_pkg::OP_ADD) w_res = r_sec + r_top;
                        else if (r_mode == sme_pkg::OP_SUB) w_res = r_sec - r_top;
                        else w_res = 32'(r_sec * r_top);
                    end
                end
                sme_pkg::OP_SQR: begin
                    if (r_cnt == '0) begin
                        w_err = sme_pkg::ERR_UNDER;
                    end else if (r_top[31]) begin
                        w_err = sme_pkg::ERR_NSQRT;
                    end else begin
                        w_npc = r_pc + 11'd1;
                        w_arith_iter = 1'b1;
                    end
                end
                sme_pkg::OP_JMP: w_npc = r_opnd[10:0];
                default: begin
                    if (r_cnt < CNT_W'(2)) begin
                        w_err = sme_pkg::ERR_UNDER;
                    end else begin
                        case (r_mode)
                            sme_pkg::OP_JB:  w_take = w_ltst;
                            sme_pkg::OP_JBE: w_take = !w_ltts;
                            sme_pkg::OP_JA:  w_take = w_ltts;
                            sme_pkg::OP_JAE: w_take = !w_ltst;
                            sme_pkg::OP_JE:  w_take = (r_sec == r_top);
                            default:         w_take = (r_sec != r_top);
                        endcase
                        w_npc = w_take ? r_opnd[10:0] : r_pc + 11'd2;
                    end
                end
            endcase
        end
    end

    assign o_status.need_iter = !r_stop && (w_err == sme_pkg::ERR_NONE) && w_arith_iter;
    assign o_status.iter_last = (r_step == 6'd31);

    // One restoring step: divider trial subtract, root trial of bit 15-step.
    assign w_trial = {r_rem[31:0], r_quo[31]} - {1'b0, r_div};
    assign w_root_next = r_quo | (32'd1 << (5'd15 - r_step[4:0]));
    assign w_strial = 35'(w_root_next[15:0]) * 35'(w_root_next[15:0]);

    // Final value of the iterative unit.
    always_comb begin
        if (r_mode == sme_pkg::OP_SQR) begin
            w_fin = ((r_top - r_quo * r_quo) > r_quo) ? r_quo + 32'd1 : r_quo;
        end else if (r_mode == sme_pkg::OP_DIV) begin
            w_fin = r_neg_q ? -r_quo : r_quo;
        end else begin
            w_fin = r_neg_r ? -r_rem[31:0] : r_rem[31:0];
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_len <= 11'd1024;
        else if (i_cfg_we) r_len <= i_cfg_wdata;
    end

    // Instruction latch and stack reads (registered memory reads).
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_beat.mode;
            r_opnd <= i_beat.operand;
            r_inval <= i_beat.in_value;
            r_top <= (r_cnt == '0) ? 32'd0 : r_stack[w_tidx];
            r_rd <= r_regs[RI_W'(i_beat.operand)];
        end
        if (i_cmd.read2) begin
            r_sec <= (r_cnt < CNT_W'(2)) ? 32'd0 : r_stack[w_sidx];
        end
    end

    // Stack memory writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !r_stop && w_err == sme_pkg::ERR_NONE) begin
            case (r_mode)
                sme_pkg::OP_PUSH:    r_stack[SP_W'(r_cnt)] <= r_opnd;
                sme_pkg::OP_PUSHREG: r_stack[SP_W'(r_cnt)] <= r_rd;
                sme_pkg::OP_IN:      r_stack[SP_W'(r_cnt)] <= r_inval;
                sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL:
                    r_stack[w_sidx] <= w_res;
                default: ;
            endcase
        end else if (i_cmd.finish) begin
            // The count already reflects the pop of divide and modulo, so the
            // result slot is the current top for every iterative instruction.
            r_stack[w_tidx] <= w_fin;
        end
    end

    // Iterative unit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_step <= 6'd0;
            r_rem <= 33'd0;
            r_quo <= (r_mode == sme_pkg::OP_SQR) ? 32'd0 : w_mag_a;
            r_div <= w_mag_b;
            r_neg_q <= r_sec[31] ^ r_top[31];
            r_neg_r <= r_sec[31];
        end else if (i_cmd.iter) begin
            r_step <= r_step + 6'd1;
            if (r_mode == sme_pkg::OP_SQR) begin
                if (r_step < 6'd16 && w_strial <= 35'(r_top)) r_quo <= w_root_next;
            end else if (!w_trial[32]) begin
                r_rem <= {1'b0, w_trial[31:0]};
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_quo[31]};
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    // Architectural state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
            r_cnt <= '0;
            r_stop <= 1'b0;
            r_err <= sme_pkg::ERR_NONE;
            for (int i = 0; i < sme_pkg::REGISTER_COUNT; i++) r_regs[i] <= 32'd0;
        end else if (i_cmd.exec) begin
            r_out.out_valid <= 1'b0;
            r_out.out_value <= 32'd0;
            if (r_stop) begin
                r_out.next_pc <= r_pc;
                r_out.halted <= 1'b1;
                r_out.error_code <= r_err;
            end else if (w_err != sme_pkg::ERR_NONE) begin
                r_stop <= 1'b1;
                r_err <= w_err;
                r_out.next_pc <= r_pc;
                r_out.halted <= 1'b1;
                r_out.error_code <= w_err;
            end else begin
                r_pc <= w_npc;
                r_out.next_pc <= w_npc;
                r_out.halted <= (r_mode == sme_pkg::OP_HLT);
                r_out.error_code <= r_err;
                if (r_mode == sme_pkg::OP_HLT) r_stop <= 1'b1;
                if (r_mode == sme_pkg::OP_OUT) begin
                    r_out.out_valid <= 1'b1;
                    r_out.out_value <= r_top;
                end
                case (r_mode)
                    sme_pkg::OP_PUSH, sme_pkg::OP_PUSHREG, sme_pkg::OP_IN:
                        r_cnt <= r_cnt + CNT_W'(1);
                    sme_pkg::OP_POP, sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
                    sme_pkg::OP_DIV, sme_pkg::OP_MOD:
                        r_cnt <= r_cnt - CNT_W'(1);
                    sme_pkg::OP_POPREG: begin
                        r_cnt <= r_cnt - CNT_W'(1);
                        r_regs[RI_W'(r_opnd)] <= r_top;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_beat = r_out;
endmodule

[design/stack_machine_execute_unit.sv]
// Top level of the stack machine execute unit.
// Depends on sme_pkg, sme_ctrl and sme_dpath.
//
// Usage:
//   The input channel (i_valid/o_stall, payload i_beat) carries one
//   instruction beat: opcode, operand word and the value for the in opcode.
//   The output channel (o_valid/i_stall, payload o_beat) returns one beat per
//   instruction: next pc, printed value, halt flag and sticky error code.
//   A beat is moved at a clock edge with valid high and stall low.
//   i_cfg_we/i_cfg_wdata write the program length; write only while idle.
// Sequencing:
//   Simple instructions go through these steps from acceptance to the result
//   beat: capture with top-of-stack read, second-entry read, execute.
//   Divide, modulo and square root add 32 steps of the shared restoring
//   unit and a finishing step. One item is in flight.
// Reset (synchronous, active low) clears pc, stack count, register file,
//   halt and error state and sets the program length to 1024.
// When the receiver stalls, the result beat holds and the input channel
//   stays stalled until the result beat is taken.
module stack_machine_execute_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sme_pkg::t_in_beat  i_beat,
    output logic               o_valid,
    input  logic               i_stall,
    output sme_pkg::t_out_beat o_beat,
    input  logic               i_cfg_we,
    input  logic [10:0]        i_cfg_wdata
);
    sme_pkg::t_cmd    w_cmd;
    sme_pkg::t_status w_status;

    sme_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .i_status(w_status), .o_cmd(w_cmd)
    );

    sme_dpath u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_beat(i_beat), .i_cmd(w_cmd),
        .o_status(w_status), .o_beat(o_beat)
    );
endmodule

[design/sme_checker.sv]
// Port-level checker of the stack machine execute unit, bound to the top.
// Depends on sme_pkg and stack_machine_execute_unit_macros.svh.
`include "stack_machine_execute_unit_macros.svh"
module sme_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input sme_pkg::t_out_beat o_beat
);
    // A stalled result beat holds.
    `SM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_beat))
    // An error code implies the halt flag.
    `SM_ASSERT_IMPL(a_err_halt, i_clk, i_rst_n,
        o_valid && o_beat.error_code != sme_pkg::ERR_NONE, o_beat.halted)
    // A printed value never comes with a halt.
    `SM_ASSERT_IMPL(a_out_nohalt, i_clk, i_rst_n, o_valid && o_beat.out_valid,
        !o_beat.halted)
    // The input is stalled while a result waits on a stalled receiver.
    `SM_ASSERT_IMPL(a_in_block, i_clk, i_rst_n, o_valid && i_stall, o_stall)
endmodule

bind stack_machine_execute_unit sme_checker u_sme_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall), .o_valid(o_valid),
    .i_stall(i_stall), .o_beat(o_beat)
);

[verif/sme_exec_checker.sv]
`timescale 1ns / 100ps
// Checker of the stack machine execute unit: predicts every result beat from the accepted
// instruction beats and compares it field by field. Depends on sme_pkg.
module sme_exec_checker
    import sme_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_beat    i_in_beat,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_beat   i_out_beat,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    output logic [10:0] o_pc,
    output int          o_depth,
    output logic [31:0] o_top,
    output int          o_pending,
    output int          o_fails,
    output int          o_results
);
    // Predicted machine state and the program length in use.
    logic [10:0] pc_r;
    logic [10:0] length_r;
    logic [31:0] stack_mem [STACK_DEPTH];
    int          depth;
    logic [31:0] regs [REGISTER_COUNT];
    logic        stopped;
    logic [3:0]  sticky;
    t_out_beat   expected_beats [$];
    int          fails;
    int          results;

    assign o_pc      = pc_r;
    assign o_depth   = depth;
    assign o_top     = (depth >= 1) ? stack_mem[depth - 1] : 32'd0;
    assign o_pending = expected_beats.size();
    assign o_fails   = fails;
    assign o_results = results;

    function automatic logic [31:0] magnitude(logic [31:0] a);
        return a[31] ? -a : a;
    endfunction

    // Square root rounded to nearest, bit by bit from the top.
    function automatic logic [31:0] rounded_sqrt(logic [31:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = 64'd0;
        for (int b = 15; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= {32'd0, x}) r = t;
        end
        if ({32'd0, x} - r * r > r) r = r + 64'd1;
        return r[31:0];
    endfunction

    // Runs one instruction on the predicted state and forms its result beat.
    task automatic execute_instruction(input t_in_beat beat, output t_out_beat res);
        int unsigned lim;
        int unsigned npc;
        int unsigned p;
        logic [3:0]  err;
        logic [31:0] opnd;
        logic [31:0] top;
        logic [31:0] sec;
        logic [31:0] r;
        logic        two_word;
        logic        is_jump;
        logic        take;
        logic        ovalid;
        logic [31:0] ov;
        lim      = (length_r > PROGRAM_WORDS) ? PROGRAM_WORDS : length_r;
        opnd     = beat.operand;
        p        = pc_r;
        npc      = p;
        err      = ERR_NONE;
        ovalid   = 1'b0;
        ov       = 32'd0;
        top      = 32'd0;
        sec      = 32'd0;
        take     = 1'b0;
        is_jump  = (beat.mode >= OP_JMP) && (beat.mode <= OP_JNE);
        two_word = is_jump || (beat.mode inside {OP_PUSH, OP_PUSHREG, OP_POPREG});
        if (!stopped) begin
            if (p >= lim || (two_word && p + 1 >= lim)) begin
                err = ERR_PC;
            end else if (beat.mode > OP_JNE) begin
                err = ERR_OPCODE;
            end else if (is_jump && (opnd[31] || opnd >= lim)) begin
                err = ERR_TARGET;
            end else begin
                if (depth >= 1) top = stack_mem[depth - 1];
                if (depth >= 2) sec = stack_mem[depth - 2];
                case (beat.mode)
                    OP_HLT: begin
                        stopped = 1'b1;
                    end
                    OP_PUSH, OP_PUSHREG, OP_IN: begin
                        if (beat.mode == OP_PUSHREG && opnd >= REGISTER_COUNT) err = ERR_REG;
                        else if (depth >= STACK_DEPTH) err = ERR_OVER;
                        else begin
                            stack_mem[depth] = (beat.mode == OP_PUSH) ? opnd :
                                (beat.mode == OP_PUSHREG) ? regs[opnd[RI_W-1:0]] :
                                beat.in_value;
                            depth++;
                            npc = p + ((beat.mode == OP_IN) ? 1 : 2);
                        end
                    end
                    OP_POP, OP_POPREG: begin
                        if (depth < 1) err = ERR_UNDER;
                        else if (beat.mode == OP_POPREG && opnd >= REGISTER_COUNT) err = ERR_REG;
                        else begin
                            if (beat.mode == OP_POPREG) regs[opnd[RI_W-1:0]] = top;
                            depth--;
                            npc = p + ((beat.mode == OP_POPREG) ? 2 : 1);
                        end
                    end
                    OP_DMP: begin
                        npc = p + 1;
                    end
                    OP_OUT: begin
                        if (depth < 1) err = ERR_UNDER;
                        else begin
                            ovalid = 1'b1;
                            ov     = top;
                            npc    = p + 1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                        if (depth < 2) err = ERR_UNDER;
                        else if ((beat.mode == OP_DIV || beat.mode == OP_MOD) && top == 0)
                            err = ERR_DIVZ;
                        else begin
                            case (beat.mode)
                                OP_ADD: r = sec + top;
                                OP_SUB: r = sec - top;
                                OP_MUL: r = sec * top;
                                OP_DIV: begin
                                    r = magnitude(sec) / magnitude(top);
                                    if (sec[31] ^ top[31]) r = -r;
                                end
                                default: begin
                                    r = magnitude(sec) % magnitude(top);
                                    if (sec[31]) r = -r;
                                end
                            endcase
                            depth--;
                            stack_mem[depth - 1] = r;
                            npc = p + 1;
                        end
                    end
                    OP_SQR: begin
                        if (depth < 1) err = ERR_UNDER;
                        else if (top[31]) err = ERR_NSQRT;
                        else begin
                            stack_mem[depth - 1] = rounded_sqrt(top);
                            npc = p + 1;
                        end
                    end
                    OP_JMP: begin
                        npc = opnd;
                    end
                    default: begin
                        if (depth < 2) err = ERR_UNDER;
                        else begin
                            case (beat.mode)
                                OP_JB:   take = $signed(sec) < $signed(top);
                                OP_JBE:  take = !($signed(top) < $signed(sec));
                                OP_JA:   take = $signed(top) < $signed(sec);
                                OP_JAE:  take = !($signed(sec) < $signed(top));
                                OP_JE:   take = (sec == top);
                                default: take = (sec != top);
                            endcase
                            npc = take ? opnd : p + 2;
                        end
                    end
                endcase
            end
            if (err != ERR_NONE) begin
                stopped = 1'b1;
                sticky  = err;
                npc     = p;
                ovalid  = 1'b0;
                ov      = 32'd0;
            end
            pc_r = npc[10:0];
        end
        res.next_pc    = pc_r;
        res.out_valid  = ovalid;
        res.out_value  = ov;
        res.halted     = stopped;
        res.error_code = sticky;
    endtask

    // Watch both channels and the configuration port on every rising edge.
    always @(posedge i_clk) begin
        t_out_beat want;
        t_out_beat next_want;
        if (!i_rst_n) begin
            pc_r     = 11'd0;
            length_r = 11'd1024;
            depth    = 0;
            stopped  = 1'b0;
            sticky   = ERR_NONE;
            fails    = 0;
            results  = 0;
            for (int k = 0; k < REGISTER_COUNT; k++) regs[k] = 32'd0;
            expected_beats.delete();
        end else begin
            if (i_cfg_we) length_r = i_cfg_wdata;
            // Compare a result beat with the oldest expectation.
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (expected_beats.size() == 0) begin
                    if (fails < 10) $display("%0t: result beat with nothing expected", $time);
                    fails++;
                end else begin
                    want = expected_beats.pop_front();
                    if (i_out_beat.next_pc !== want.next_pc ||
                        i_out_beat.out_valid !== want.out_valid ||
                        i_out_beat.out_value !== want.out_value ||
                        i_out_beat.halted !== want.halted ||
                        i_out_beat.error_code !== want.error_code) begin
                        if (fails < 10)
                            $display({"%0t: mismatch: expected pc %0d ov %b val %h halt %b ",
                                "err %0d, got pc %0d ov %b val %h halt %b err %0d"}, $time,
                                want.next_pc, want.out_valid, want.out_value, want.halted,
                                want.error_code, i_out_beat.next_pc, i_out_beat.out_valid,
                                i_out_beat.out_value, i_out_beat.halted,
                                i_out_beat.error_code);
                        fails++;
                    end
                end
            end
            // Predict the result of an accepted instruction beat.
            if (i_in_valid && !i_in_stall) begin
                execute_instruction(i_in_beat, next_want);
                expected_beats.push_back(next_want);
            end
        end
    end
endmodule

[verif/tb_stack_machine_execute_unit.sv]
`timescale 1ns / 100ps
// Testbench top of the stack machine execute unit: makes the instruction stream and gives
// the verdict. Depends on sme_pkg, stack_machine_execute_unit and sme_exec_checker.
module tb_stack_machine_execute_unit;
    import sme_pkg::*;

    localparam int RESET_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 275;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum {
        END_HLT, END_OPCODE, END_TARGET, END_UNDER, END_OVER, END_REG, END_DIVZ,
        END_NSQRT, END_PC_JUMP, END_LEN_ZERO, END_LEN_ONE
    } t_ending;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in_beat    i_beat = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out_beat   o_beat;
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_wdata = 11'd0;

    logic [10:0] chk_pc;
    int          chk_depth;
    logic [31:0] chk_top;
    int          chk_pending;
    int          chk_fails;
    int          chk_results;

    int          send_pct = 0;
    int          recv_pct = 0;
    int          hold_left = 0;
    int          idle_cycles = 0;
    int          sent = 0;
    int          depth_goal = 8;
    int unsigned cur_len = 1024;
    t_ending     ending;

    stack_machine_execute_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_beat     (i_beat),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_beat     (o_beat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    sme_exec_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_stall (o_stall),
        .i_in_beat  (i_beat),
        .i_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_out_beat (o_beat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_pc       (chk_pc),
        .o_depth    (chk_depth),
        .o_top      (chk_top),
        .o_pending  (chk_pending),
        .o_fails    (chk_fails),
        .o_results  (chk_results)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: a long hold when asked, otherwise random stalls.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else begin
            i_stall = ($urandom_range(0, 99) < recv_pct);
        end
    end

    // Watchdog on cycles in which no beat moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in_beat make_beat(logic [4:0] mode, logic [31:0] opnd,
                                           logic [31:0] value);
        t_in_beat b;
        b.mode     = mode;
        b.operand  = opnd;
        b.in_value = value;
        return b;
    endfunction

    // Data values that lean toward the extremes and small numbers.
    function automatic logic [31:0] mixed_value();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 40)) - 32'd20;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Picks an instruction that runs without error from the predicted state.
    function automatic t_in_beat pick_instruction();
        t_in_beat    b;
        int unsigned lim;
        bit          ok;
        lim = (cur_len > PROGRAM_WORDS) ? PROGRAM_WORDS : cur_len;
        b.operand  = $urandom;
        b.in_value = mixed_value();
        if (chk_pc + 3 >= lim) begin
            b.mode    = OP_JMP;
            b.operand = $urandom_range(0, lim - 4);
            return b;
        end
        do begin
            b.mode = 5'($urandom_range(OP_PUSH, OP_JNE));
            if (chk_depth < depth_goal && $urandom_range(0, 1))
                b.mode = $urandom_range(0, 1) ? OP_PUSH : ($urandom_range(0, 1) ? OP_IN : OP_PUSHREG);
            case (b.mode)
                OP_PUSH, OP_PUSHREG, OP_IN: ok = chk_depth < STACK_DEPTH;
                OP_POP, OP_POPREG, OP_OUT:  ok = chk_depth >= 1;
                OP_SQR:                     ok = chk_depth >= 1 && !chk_top[31];
                OP_ADD, OP_SUB, OP_MUL:     ok = chk_depth >= 2;
                OP_DIV, OP_MOD:             ok = chk_depth >= 2 && chk_top != 32'd0;
                OP_DMP, OP_JMP:             ok = 1'b1;
                default:                    ok = chk_depth >= 2;
            endcase
        end while (!ok);
        if (b.mode == OP_PUSH) b.operand = mixed_value();
        if (b.mode == OP_PUSHREG || b.mode == OP_POPREG)
            b.operand = $urandom_range(0, REGISTER_COUNT - 1);
        if (b.mode >= OP_JMP) b.operand = $urandom_range(0, lim - 4);
        return b;
    endfunction

    // Offers one beat after a random gap and holds it until it is taken.
    task automatic send_beat(input t_in_beat b);
        while ($urandom_range(0, 99) < send_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_beat  = b;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        i_valid = 1'b0;
        sent++;
    endtask

    // Waits for every expected result, then lets the channels settle.
    task automatic drain();
        while (chk_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_length(input int unsigned len);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = len[10:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cur_len  = len;
    endtask

    // Back to address zero, quiet, new length, then a run of random programs.
    task automatic run_phase(input int unsigned len, input int sp, input int rp, input bit hold);
        send_beat(make_beat(OP_JMP, 32'd0, $urandom));
        drain();
        write_length(len);
        send_pct   = sp;
        recv_pct   = rp;
        depth_goal = $urandom_range(2, STACK_DEPTH);
        if (hold) hold_left = HOLD_CYCLES;
        repeat (PHASE_ITEMS) send_beat(pick_instruction());
    endtask

    initial begin
        t_in_beat b;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: wrap, division overflow, rounding, registers and every jump.
        send_beat(make_beat(OP_PUSH, 32'h7FFF_FFFF, 32'd0));
        send_beat(make_beat(OP_PUSH, 32'h7FFF_FFFF, 32'd0));
        send_beat(make_beat(OP_ADD, $urandom, $urandom));
        send_beat(make_beat(OP_OUT, $urandom, $urandom));
        send_beat(make_beat(OP_IN, $urandom, 32'h8000_0000));
        send_beat(make_beat(OP_PUSH, 32'hFFFF_FFFF, 32'd0));
        send_beat(make_beat(OP_DIV, $urandom, $urandom));
        send_beat(make_beat(OP_PUSH, 32'hFFFF_FFFF, 32'd0));
        send_beat(make_beat(OP_MOD, $urandom, $urandom));
        send_beat(make_beat(OP_PUSH, -32'sd7, 32'd0));
        send_beat(make_beat(OP_PUSH, 32'd2, 32'd0));
        send_beat(make_beat(OP_DIV, $urandom, $urandom));
        send_beat(make_beat(OP_MUL, $urandom, $urandom));
        send_beat(make_beat(OP_PUSH, 32'h7FFF_FFFF, 32'd0));
        send_beat(make_beat(OP_SQR, $urandom, $urandom));
        send_beat(make_beat(OP_POPREG, 32'd7, $urandom));
        send_beat(make_beat(OP_PUSHREG, 32'd7, $urandom));
        send_beat(make_beat(OP_PUSHREG, 32'd0, $urandom));
        send_beat(make_beat(OP_SUB, $urandom, $urandom));
        send_beat(make_beat(OP_DMP, $urandom, $urandom));
        send_beat(make_beat(OP_POP, $urandom, $urandom));
        for (int m = OP_JB; m <= OP_JNE; m++)
            send_beat(make_beat(5'(m), $urandom_range(0, 1019), $urandom));
        send_beat(make_beat(OP_JMP, $urandom_range(0, 1019), $urandom));

        // Random programs under several lengths and handshake patterns.
        run_phase(2047, 0, 0, 1'b0);
        run_phase($urandom_range(16, 64), 47, 0, 1'b0);
        run_phase(1024, 0, 47, 1'b0);
        run_phase($urandom_range(8, 1023), 14, 14, 1'b0);
        run_phase(8, 0, 0, 1'b1);

        // Stop the machine one way, then keep feeding it while it stays stopped.
        send_beat(make_beat(OP_JMP, 32'd0, $urandom));
        drain();
        write_length(1024);
        send_pct = 14;
        recv_pct = 14;
        ending = t_ending'($urandom_range(END_HLT, END_LEN_ONE));
        case (ending)
            END_HLT:    send_beat(make_beat(OP_HLT, $urandom, $urandom));
            END_OPCODE: send_beat(make_beat(5'($urandom_range(21, 31)), $urandom, $urandom));
            END_TARGET: begin
                b = make_beat(5'($urandom_range(OP_JMP, OP_JNE)), $urandom | 32'h8000_0000,
                              $urandom);
                if ($urandom_range(0, 1)) b.operand = $urandom_range(1024, 32'h7FFF_FFFF);
                send_beat(b);
            end
            END_UNDER: begin
                while (chk_depth > 0) send_beat(make_beat(OP_POP, $urandom, $urandom));
                send_beat(make_beat($urandom_range(0, 1) ? OP_POP : OP_ADD, $urandom, $urandom));
            end
            END_OVER: begin
                while (chk_depth < STACK_DEPTH)
                    send_beat(make_beat(OP_PUSH, $urandom, $urandom));
                send_beat(make_beat(OP_PUSH, $urandom, $urandom));
            end
            END_REG: begin
                send_beat(make_beat(OP_PUSH, $urandom, $urandom));
                b = make_beat($urandom_range(0, 1) ? OP_POPREG : OP_PUSHREG, $urandom, $urandom);
                if (b.operand >= 0 && b.operand < REGISTER_COUNT) b.operand = REGISTER_COUNT;
                send_beat(b);
            end
            END_DIVZ: begin
                send_beat(make_beat(OP_PUSH, $urandom, $urandom));
                send_beat(make_beat(OP_PUSH, 32'd0, $urandom));
                send_beat(make_beat($urandom_range(0, 1) ? OP_DIV : OP_MOD, $urandom, $urandom));
            end
            END_NSQRT: begin
                send_beat(make_beat(OP_PUSH, $urandom | 32'h8000_0000, $urandom));
                send_beat(make_beat(OP_SQR, $urandom, $urandom));
            end
            END_PC_JUMP: begin
                send_beat(make_beat(OP_JMP, 32'd1023, $urandom));
                send_beat(make_beat(OP_PUSH, $urandom, $urandom));
            end
            END_LEN_ZERO: begin
                drain();
                write_length(0);
                send_beat(make_beat(OP_DMP, $urandom, $urandom));
            end
            default: begin
                drain();
                write_length(1);
                send_beat(make_beat(OP_DMP, $urandom, $urandom));
                send_beat(make_beat(OP_DMP, $urandom, $urandom));
            end
        endcase
        repeat (12) send_beat(make_beat(5'($urandom), $urandom, $urandom));

        drain();
        $display("Sent %0d instructions: directed set, five random phases, ending %s.",
                 sent, ending.name());
        $display("Checked %0d result beats, %0d failures.", chk_results, chk_fails);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

[stack_machine_execute_unit.f]
+incdir+design
design/sme_pkg.sv
design/sme_ctrl.sv
design/sme_dpath.sv
design/stack_machine_execute_unit.sv
design/sme_checker.sv
verif/sme_exec_checker.sv
verif/tb_stack_machine_execute_unit.sv
